### hw/rtl/tsm_pkg.sv
package tsm_pkg;

   localparam int unsigned OP_WIDTH     = 4;
   localparam int unsigned STATUS_WIDTH = 3;

   // Instruction classes. Opcode values above halt are folded into halt
   // by the front end, so the back end only ever sees these members.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH  = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_MUL   = 4'd3,
      OP_DUP   = 4'd4,
      OP_PRINT = 4'd5,
      OP_CALL  = 4'd6,
      OP_RET   = 4'd7,
      OP_HALT  = 4'd8
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK          = 3'd0,
      ST_DATA_UNDER  = 3'd1,
      ST_DATA_OVER   = 3'd2,
      ST_RET_UNDER   = 3'd3,
      ST_RET_OVER    = 3'd4,
      ST_HALTED      = 3'd5
   } status_type;

endpackage

### hw/rtl/tsm_queue.sv
module tsm_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   // Two-entry circular buffer; a write and a read may both complete in
   // the same cycle, so one entry per cycle flows through while rd_en stays high.
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_wr;
   logic             do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hw/rtl/tsm_front.sv
module tsm_front #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned ADDR_WIDTH = 10
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push,
   output logic                                       full,
   input  logic [tsm_pkg::OP_WIDTH-1:0]               opcode,
   input  logic [DATA_WIDTH-1:0]                      push_value,
   input  logic [ADDR_WIDTH-1:0]                      call_target,
   input  logic                                       item_pop,
   output logic                                       item_empty,
   output logic [tsm_pkg::OP_WIDTH+DATA_WIDTH+ADDR_WIDTH-1:0] item_data
);
   import tsm_pkg::*;

   localparam int unsigned ITEM_WIDTH = OP_WIDTH + DATA_WIDTH + ADDR_WIDTH;

   op_type                op_class;
   logic [ITEM_WIDTH-1:0] item_in;

   // Every opcode beyond the defined set behaves as halt.
   always_comb begin
      if (opcode > OP_HALT) begin
         op_class = OP_HALT;
      end else begin
         op_class = op_type'(opcode);
      end
      item_in = {op_class, push_value, call_target};
   end

   tsm_queue #(
      .WIDTH (ITEM_WIDTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (item_in),
      .full    (full),
      .rd_en   (item_pop),
      .rd_data (item_data),
      .empty   (item_empty)
   );

endmodule

### hw/rtl/tsm_back.sv
module tsm_back #(
   parameter int unsigned DATA_WIDTH         = 32,
   parameter int unsigned ADDR_WIDTH         = 10,
   parameter int unsigned DATA_STACK_DEPTH   = 16,
   parameter int unsigned RETURN_STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [ADDR_WIDTH-1:0] csr_address,
   input  logic                  item_empty,
   input  logic [tsm_pkg::OP_WIDTH+DATA_WIDTH+ADDR_WIDTH-1:0] item_data,
   output logic                  item_pop,
   input  logic                  out_full,
   output logic                  out_push,
   output logic [ADDR_WIDTH+DATA_WIDTH+tsm_pkg::STATUS_WIDTH+1:0] out_data
);
   import tsm_pkg::*;

   localparam int unsigned DCW = $clog2(DATA_STACK_DEPTH + 1);
   localparam int unsigned RCW = $clog2(RETURN_STACK_DEPTH + 1);

   // Stacks are shift structures with the top in cell zero, so every
   // operation only touches the two top cells and the neighbors shift.
   logic [DATA_WIDTH-1:0] ds_ff [DATA_STACK_DEPTH];
   logic [ADDR_WIDTH-1:0] rs_ff [RETURN_STACK_DEPTH];
   logic [DCW-1:0]        dd_ff;
   logic [DCW-1:0]        dd_in;
   logic [RCW-1:0]        rd_ff;
   logic [RCW-1:0]        rd_in;
   logic [ADDR_WIDTH-1:0] ip_ff;
   logic [ADDR_WIDTH-1:0] ip_in;
   logic                  stopped_ff;
   logic                  stopped_in;

   op_type                item_op;
   logic [DATA_WIDTH-1:0] item_value;
   logic [ADDR_WIDTH-1:0] item_target;
   logic                  fire;

   logic                  ds_load;
   logic                  ds_down;
   logic                  ds_up;
   logic [DATA_WIDTH-1:0] ds_value;
   logic                  rs_down;
   logic                  rs_up;
   logic [DATA_WIDTH-1:0] alu_result;
   logic                  halt_op;

   logic [ADDR_WIDTH-1:0] res_next;
   logic                  res_pvalid;
   logic [DATA_WIDTH-1:0] res_pval;
   logic                  res_halted;
   status_type            res_status;

   assign item_op     = op_type'(item_data[OP_WIDTH+DATA_WIDTH+ADDR_WIDTH-1 -: OP_WIDTH]);
   assign item_value  = item_data[DATA_WIDTH+ADDR_WIDTH-1 -: DATA_WIDTH];
   assign item_target = item_data[ADDR_WIDTH-1:0];

   assign fire     = !item_empty && !out_full;
   assign item_pop = fire;
   assign out_push = fire;
   assign out_data = {res_next, res_pvalid, res_pval, res_halted, res_status};

   // Second entry is the left operand, top is the right operand.
   always_comb begin
      unique case (item_op)
         OP_ADD:  alu_result = ds_ff[1] + ds_ff[0];
         OP_SUB:  alu_result = ds_ff[1] - ds_ff[0];
         default: alu_result = ds_ff[1] * ds_ff[0];
      endcase
   end

   always_comb begin
      ds_load    = 1'b0;
      ds_down    = 1'b0;
      ds_up      = 1'b0;
      ds_value   = item_value;
      rs_down    = 1'b0;
      rs_up      = 1'b0;
      halt_op    = 1'b0;
      dd_in      = dd_ff;
      rd_in      = rd_ff;
      res_next   = ip_ff;
      res_pvalid = 1'b0;
      res_pval   = '0;
      res_status = ST_OK;

      unique case (item_op)
         OP_PUSH: begin
            if (dd_ff == DCW'(DATA_STACK_DEPTH)) begin
               res_status = ST_DATA_OVER;
            end else begin
               ds_load  = 1'b1;
               ds_down  = 1'b1;
               dd_in    = dd_ff + DCW'(1);
               res_next = ip_ff + ADDR_WIDTH'(2);
            end
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            if (dd_ff < DCW'(2)) begin
               res_status = ST_DATA_UNDER;
            end else begin
               ds_load  = 1'b1;
               ds_up    = 1'b1;
               ds_value = alu_result;
               dd_in    = dd_ff - DCW'(1);
               res_next = ip_ff + ADDR_WIDTH'(1);
            end
         end
         OP_DUP: begin
            if (dd_ff == '0) begin
               res_status = ST_DATA_UNDER;
            end else if (dd_ff == DCW'(DATA_STACK_DEPTH)) begin
               res_status = ST_DATA_OVER;
            end else begin
               ds_down  = 1'b1;
               dd_in    = dd_ff + DCW'(1);
               res_next = ip_ff + ADDR_WIDTH'(1);
            end
         end
         OP_PRINT: begin
            if (dd_ff == '0) begin
               res_status = ST_DATA_UNDER;
            end else begin
               ds_up      = 1'b1;
               dd_in      = dd_ff - DCW'(1);
               res_pvalid = 1'b1;
               res_pval   = ds_ff[0];
               res_next   = ip_ff + ADDR_WIDTH'(1);
            end
         end
         OP_CALL: begin
            if (rd_ff == RCW'(RETURN_STACK_DEPTH)) begin
               res_status = ST_RET_OVER;
            end else begin
               rs_down  = 1'b1;
               rd_in    = rd_ff + RCW'(1);
               res_next = item_target;
            end
         end
         OP_RET: begin
            if (rd_ff == '0) begin
               res_status = ST_RET_UNDER;
            end else begin
               rs_up    = 1'b1;
               rd_in    = rd_ff - RCW'(1);
               res_next = rs_ff[0];
            end
         end
         default: begin
            halt_op = 1'b1;
         end
      endcase

      // A stopped machine changes nothing and only reports that it stopped.
      if (stopped_ff) begin
         ds_load    = 1'b0;
         ds_down    = 1'b0;
         ds_up      = 1'b0;
         rs_down    = 1'b0;
         rs_up      = 1'b0;
         dd_in      = dd_ff;
         rd_in      = rd_ff;
         res_next   = ip_ff;
         res_pvalid = 1'b0;
         res_pval   = '0;
         res_status = ST_HALTED;
      end

      res_halted = stopped_ff || halt_op || (res_status != ST_OK);

      if (!fire) begin
         ds_load = 1'b0;
         ds_down = 1'b0;
         ds_up   = 1'b0;
         rs_down = 1'b0;
         rs_up   = 1'b0;
         dd_in   = dd_ff;
         rd_in   = rd_ff;
      end

      stopped_in = fire ? res_halted : stopped_ff;
      if (csr_write) begin
         ip_in = csr_address;
      end else if (fire) begin
         ip_in = res_next;
      end else begin
         ip_in = ip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dd_ff      <= '0;
         rd_ff      <= '0;
         ip_ff      <= '0;
         stopped_ff <= 1'b0;
      end else begin
         dd_ff      <= dd_in;
         rd_ff      <= rd_in;
         ip_ff      <= ip_in;
         stopped_ff <= stopped_in;
      end
   end

   for (genvar i = 0; i < DATA_STACK_DEPTH; i++) begin : g_ds
      if (i == 0) begin : g_top
         always_ff @(posedge clock) begin
            if (ds_load) begin
               ds_ff[i] <= ds_value;
            end else if (ds_up) begin
               ds_ff[i] <= ds_ff[i+1];
            end
         end
      end else if (i == DATA_STACK_DEPTH - 1) begin : g_bottom
         always_ff @(posedge clock) begin
            if (ds_down) begin
               ds_ff[i] <= ds_ff[i-1];
            end
         end
      end else begin : g_mid
         always_ff @(posedge clock) begin
            if (ds_down) begin
               ds_ff[i] <= ds_ff[i-1];
            end else if (ds_up) begin
               ds_ff[i] <= ds_ff[i+1];
            end
         end
      end
   end

   for (genvar i = 0; i < RETURN_STACK_DEPTH; i++) begin : g_rs
      if (i == 0 && RETURN_STACK_DEPTH == 1) begin : g_only
         always_ff @(posedge clock) begin
            if (rs_down) begin
               rs_ff[i] <= ip_ff + ADDR_WIDTH'(2);
            end
         end
      end else if (i == 0) begin : g_top
         always_ff @(posedge clock) begin
            if (rs_down) begin
               rs_ff[i] <= ip_ff + ADDR_WIDTH'(2);
            end else if (rs_up) begin
               rs_ff[i] <= rs_ff[i+1];
            end
         end
      end else if (i == RETURN_STACK_DEPTH - 1) begin : g_bottom
         always_ff @(posedge clock) begin
            if (rs_down) begin
               rs_ff[i] <= rs_ff[i-1];
            end
         end
      end else begin : g_mid
         always_ff @(posedge clock) begin
            if (rs_down) begin
               rs_ff[i] <= rs_ff[i-1];
            end else if (rs_up) begin
               rs_ff[i] <= rs_ff[i+1];
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_stopped_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped machine resumed without reset");

   a_data_depth_range: assert property (@(posedge clock) disable iff (reset)
      dd_ff <= DCW'(DATA_STACK_DEPTH))
      else $error("data stack depth beyond capacity");

   a_ret_depth_range: assert property (@(posedge clock) disable iff (reset)
      rd_ff <= RCW'(RETURN_STACK_DEPTH))
      else $error("return stack depth beyond capacity");

   a_print_is_clean: assert property (@(posedge clock) disable iff (reset)
      fire && res_pvalid |-> (res_status == ST_OK) && !res_halted)
      else $error("print reported together with a fault or halt");

   a_fault_stops: assert property (@(posedge clock) disable iff (reset)
      fire && !stopped_ff && (res_status != ST_OK) |=> stopped_ff && $stable(dd_ff))
      else $error("fault did not stop the machine or changed the data stack");
`endif

endmodule

### hw/rtl/threaded_stack_machine_core_unit.sv
// Two-stack machine core: executes one decoded instruction per request.
//
// Requests enter through a queue-style port: an instruction is taken at a
// clock edge where push is high and full is low. Results leave the same
// way: while empty is low the oldest result sits on the rsp_ ports, and it
// is consumed at an edge where pop is high. One result comes back for each
// request, in request order.
//
// The entry address is written through its own valid/ready channel (ready
// is always high); a write also restarts the instruction address there.
// Writes are expected only while no request is in flight.
//
// A taken request waits in the request queue until it is executed, and
// its result waits in the result queue until it is popped. Throughput is
// one request per cycle while the result queue is not full.
//
// Reset clears both stack depths, the stopped flag, the instruction address
// and all queues. When the consumer stops popping, results collect in the
// two-entry output queue, then execution pauses and the two-entry request
// queue fills, after which full rises. Nothing is ever dropped.
module threaded_stack_machine_core_unit #(
   parameter int unsigned DATA_WIDTH         = 32,
   parameter int unsigned ADDR_WIDTH         = 10,
   parameter int unsigned DATA_STACK_DEPTH   = 16,
   parameter int unsigned RETURN_STACK_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 push,
   output logic                                 full,
   input  logic [tsm_pkg::OP_WIDTH-1:0]         req_opcode,
   input  logic signed [DATA_WIDTH-1:0]         req_push_value,
   input  logic [ADDR_WIDTH-1:0]                req_call_target,
   // Result channel.
   output logic                                 empty,
   input  logic                                 pop,
   output logic [ADDR_WIDTH-1:0]                rsp_next_address,
   output logic                                 rsp_print_valid,
   output logic signed [DATA_WIDTH-1:0]         rsp_print_value,
   output logic                                 rsp_halted,
   output logic [tsm_pkg::STATUS_WIDTH-1:0]     rsp_status,
   // Entry address register write channel.
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [ADDR_WIDTH-1:0]                csr_entry_address
);
   import tsm_pkg::*;

   localparam int unsigned ITEM_WIDTH   = OP_WIDTH + DATA_WIDTH + ADDR_WIDTH;
   localparam int unsigned RESULT_WIDTH = ADDR_WIDTH + DATA_WIDTH + STATUS_WIDTH + 2;

   logic                    item_empty;
   logic                    item_pop;
   logic [ITEM_WIDTH-1:0]   item_data;
   logic                    out_full;
   logic                    out_push;
   logic [RESULT_WIDTH-1:0] out_data;
   logic [RESULT_WIDTH-1:0] rsp_data;

   // The register port never stalls.
   assign ready = 1'b1;

   // Front end: folds undefined opcodes into halt and buffers requests.
   tsm_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .opcode      (req_opcode),
      .push_value  (req_push_value),
      .call_target (req_call_target),
      .item_pop    (item_pop),
      .item_empty  (item_empty),
      .item_data   (item_data)
   );

   // Back end: owns both stacks, the instruction address and the stop flag.
   tsm_back #(
      .DATA_WIDTH         (DATA_WIDTH),
      .ADDR_WIDTH         (ADDR_WIDTH),
      .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
      .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (valid && ready),
      .csr_address (csr_entry_address),
      .item_empty  (item_empty),
      .item_data   (item_data),
      .item_pop    (item_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   // Output queue decouples execution from the consumer.
   tsm_queue #(
      .WIDTH (RESULT_WIDTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   // Result layout: next address, print flag, print value, halted, status.
   assign rsp_next_address = rsp_data[RESULT_WIDTH-1 -: ADDR_WIDTH];
   assign rsp_print_valid  = rsp_data[DATA_WIDTH+STATUS_WIDTH+1];
   assign rsp_print_value  = rsp_data[DATA_WIDTH+STATUS_WIDTH -: DATA_WIDTH];
   assign rsp_halted       = rsp_data[STATUS_WIDTH];
   assign rsp_status       = rsp_data[STATUS_WIDTH-1:0];

endmodule

### bench/tb_threaded_stack_machine_core_unit.sv
module tb_threaded_stack_machine_core_unit;
   import tsm_pkg::*;

   localparam int unsigned DW          = 32;
   localparam int unsigned AW          = 10;
   localparam int unsigned DSTK_DEPTH  = 16;
   localparam int unsigned RSTK_DEPTH  = 16;
   localparam int          NUM_PHASES  = 5;
   localparam int          PHASE_ITEMS = 215;
   localparam int          TAIL_ITEMS  = 24;
   // A request passes through the request and the result queue, so the idle
   // cycles below cover the pipeline after the last result has been seen.
   localparam int          SETTLE_CYCLES = 6;
   localparam int          HOLD_AFTER    = 300;
   localparam int          HOLD_CYCLES   = 90;
   localparam int          CYCLE_LIMIT   = 200000;

   // One decoded instruction as it is offered on the request ports.
   typedef struct {
      logic [OP_WIDTH-1:0] opcode;
      logic [DW-1:0]       push_value;
      logic [AW-1:0]       call_target;
   } instr_t;

   // What the core reports back for one instruction.
   typedef struct {
      logic [AW-1:0]           next_address;
      logic                    print_valid;
      logic [DW-1:0]           print_value;
      logic                    halted;
      logic [STATUS_WIDTH-1:0] status;
   } outcome_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   logic [OP_WIDTH-1:0]      req_opcode = '0;
   logic signed [DW-1:0]     req_push_value = '0;
   logic [AW-1:0]            req_call_target = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   logic [AW-1:0]            rsp_next_address;
   logic                     rsp_print_valid;
   logic signed [DW-1:0]     rsp_print_value;
   logic                     rsp_halted;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic                     valid = 1'b0;
   logic                     ready;
   logic [AW-1:0]            csr_entry_address = '0;

   threaded_stack_machine_core_unit #(
      .DATA_WIDTH(DW),
      .ADDR_WIDTH(AW),
      .DATA_STACK_DEPTH(DSTK_DEPTH),
      .RETURN_STACK_DEPTH(RSTK_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_opcode(req_opcode),
      .req_push_value(req_push_value),
      .req_call_target(req_call_target),
      .empty(empty),
      .pop(pop),
      .rsp_next_address(rsp_next_address),
      .rsp_print_valid(rsp_print_valid),
      .rsp_print_value(rsp_print_value),
      .rsp_halted(rsp_halted),
      .rsp_status(rsp_status),
      .valid(valid),
      .ready(ready),
      .csr_entry_address(csr_entry_address)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Machine state as the bench expects it to be. It advances once for
   // every request the core accepts and once for every entry address
   // write, so it always describes the instruction about to execute.
   // ------------------------------------------------------------------
   logic [DW-1:0] dstk [DSTK_DEPTH];
   logic [AW-1:0] rstk [RSTK_DEPTH];
   int unsigned   dstk_depth = 0;
   int unsigned   rstk_depth = 0;
   logic [AW-1:0] exec_addr = '0;
   logic          machine_stopped = 1'b0;

   outcome_t      expected_results[$];
   instr_t        pending[$];

   // Depths the stimulus generator assumes, so that it can build programs
   // that stay legal and only fail where a fault is planned on purpose.
   int            plan_ddepth = 0;
   int            plan_rdepth = 0;
   bit            climbing = 1'b1;
   int            mode_left = 0;

   bit            idle_on = 1'b1;
   int            mismatches = 0;
   int            results_seen = 0;
   int            cycle_count = 0;

   // Executes one instruction against the expected machine state and
   // returns what the core should report for it. Any stack fault, a halt
   // or an opcode above halt stops the machine for good; after that every
   // request only reports the already-halted status.
   function automatic outcome_t execute_instr(instr_t ins);
      outcome_t      o;
      logic [DW-1:0] lhs;
      logic [DW-1:0] rhs;
      o.next_address = exec_addr;
      o.print_valid  = 1'b0;
      o.print_value  = '0;
      o.status       = ST_OK;
      if (machine_stopped) begin
         o.status = ST_HALTED;
      end else begin
         case (ins.opcode)
            OP_PUSH: begin
               if (dstk_depth >= DSTK_DEPTH) begin
                  o.status = ST_DATA_OVER;
               end else begin
                  dstk[dstk_depth] = ins.push_value;
                  dstk_depth++;
                  o.next_address = exec_addr + AW'(2);
               end
            end
            OP_ADD, OP_SUB, OP_MUL: begin
               if (dstk_depth < 2) begin
                  o.status = ST_DATA_UNDER;
               end else begin
                  rhs = dstk[dstk_depth-1];
                  lhs = dstk[dstk_depth-2];
                  dstk_depth--;
                  if (ins.opcode == OP_ADD) begin
                     dstk[dstk_depth-1] = lhs + rhs;
                  end else if (ins.opcode == OP_SUB) begin
                     dstk[dstk_depth-1] = lhs - rhs;
                  end else begin
                     dstk[dstk_depth-1] = lhs * rhs;
                  end
                  o.next_address = exec_addr + AW'(1);
               end
            end
            OP_DUP: begin
               if (dstk_depth == 0) begin
                  o.status = ST_DATA_UNDER;
               end else if (dstk_depth >= DSTK_DEPTH) begin
                  o.status = ST_DATA_OVER;
               end else begin
                  dstk[dstk_depth] = dstk[dstk_depth-1];
                  dstk_depth++;
                  o.next_address = exec_addr + AW'(1);
               end
            end
            OP_PRINT: begin
               if (dstk_depth == 0) begin
                  o.status = ST_DATA_UNDER;
               end else begin
                  dstk_depth--;
                  o.print_valid  = 1'b1;
                  o.print_value  = dstk[dstk_depth];
                  o.next_address = exec_addr + AW'(1);
               end
            end
            OP_CALL: begin
               if (rstk_depth >= RSTK_DEPTH) begin
                  o.status = ST_RET_OVER;
               end else begin
                  // The return address skips the target cell.
                  rstk[rstk_depth] = exec_addr + AW'(2);
                  rstk_depth++;
                  o.next_address = ins.call_target;
               end
            end
            OP_RET: begin
               if (rstk_depth == 0) begin
                  o.status = ST_RET_UNDER;
               end else begin
                  rstk_depth--;
                  o.next_address = rstk[rstk_depth];
               end
            end
            default: begin
               // Halt, and every opcode beyond it, stops without a fault.
               machine_stopped = 1'b1;
            end
         endcase
         if (o.status != ST_OK) begin
            machine_stopped = 1'b1;
         end
         exec_addr = o.next_address;
      end
      o.halted = machine_stopped;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus generation. Programs are mostly legal so that the stacks
   // wander through their whole depth range; the one planned stop comes
   // at the very end, because nothing but reset clears the stopped flag.
   // ------------------------------------------------------------------
   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_arith();
      case ($urandom_range(0, 2))
         0: return OP_ADD;
         1: return OP_SUB;
         default: return OP_MUL;
      endcase
   endfunction

   function automatic bit plan_allows(logic [OP_WIDTH-1:0] op);
      case (op)
         OP_PUSH:                return plan_ddepth < DSTK_DEPTH;
         OP_ADD, OP_SUB, OP_MUL: return plan_ddepth >= 2;
         OP_DUP:                 return plan_ddepth >= 1 && plan_ddepth < DSTK_DEPTH;
         OP_PRINT:               return plan_ddepth >= 1;
         OP_CALL:                return plan_rdepth < RSTK_DEPTH;
         OP_RET:                 return plan_rdepth >= 1;
         default:                return 1'b0;
      endcase
   endfunction

   task automatic queue_instr(logic [OP_WIDTH-1:0] op, logic [DW-1:0] val,
                              logic [AW-1:0] tgt);
      instr_t ins;
      ins.opcode      = op;
      ins.push_value  = val;
      ins.call_target = tgt;
      pending.push_back(ins);
      case (op)
         OP_PUSH, OP_DUP:                  plan_ddepth++;
         OP_ADD, OP_SUB, OP_MUL, OP_PRINT: plan_ddepth--;
         OP_CALL:                          plan_rdepth++;
         OP_RET:                           plan_rdepth--;
         default: ;
      endcase
   endtask

   // One legal instruction. The generator alternates between stretches that
   // tend to grow the stacks and stretches that tend to shrink them, so both
   // stacks regularly reach empty and completely full.
   task automatic queue_random_instr();
      logic [OP_WIDTH-1:0] op;
      int                  roll;
      if (mode_left == 0) begin
         climbing  = 1'($urandom_range(0, 1));
         mode_left = $urandom_range(5, 30);
      end
      mode_left--;
      do begin
         roll = $urandom_range(0, 99);
         if (climbing) begin
            op = roll < 40 ? OP_PUSH : roll < 55 ? OP_DUP : roll < 75 ? OP_CALL :
                 roll < 85 ? pick_arith() : roll < 90 ? OP_PRINT : OP_RET;
         end else begin
            op = roll < 10 ? OP_PUSH : roll < 15 ? OP_DUP : roll < 25 ? OP_CALL :
                 roll < 60 ? pick_arith() : roll < 80 ? OP_PRINT : OP_RET;
         end
      end while (!plan_allows(op));
      queue_instr(op, pick_value(), AW'($urandom_range(0, (1 << AW) - 1)));
   endtask

   // Wrapping arithmetic at the signed limits, duplicate, print, and calls
   // to both ends of the address space.
   task automatic queue_directed();
      queue_instr(OP_PUSH, 32'h7fff_ffff, '0);
      queue_instr(OP_PUSH, 32'h0000_0001, '1);
      queue_instr(OP_ADD, '1, '0);
      queue_instr(OP_PRINT, '0, '1);
      queue_instr(OP_PUSH, 32'h8000_0000, '0);
      queue_instr(OP_PUSH, 32'h0000_0001, '0);
      queue_instr(OP_SUB, '0, '0);
      queue_instr(OP_DUP, '0, '0);
      queue_instr(OP_PRINT, '0, '0);
      queue_instr(OP_PRINT, '0, '0);
      queue_instr(OP_PUSH, 32'hffff_ffff, '0);
      queue_instr(OP_PUSH, 32'h8000_0000, '0);
      queue_instr(OP_MUL, '0, '0);
      queue_instr(OP_PRINT, '0, '0);
      queue_instr(OP_CALL, '0, '1);
      queue_instr(OP_CALL, '1, '0);
      queue_instr(OP_RET, '0, '0);
      queue_instr(OP_RET, '0, '0);
   endtask

   // The run ends the program in one of the ways the machine can stop: a
   // plain halt, an opcode above halt, or one of the four stack faults. The
   // stacks are first walked to the edge that the chosen fault needs.
   // Afterwards a tail of arbitrary opcodes must all report already halted.
   task automatic queue_stop_and_tail();
      case ($urandom_range(0, 5))
         0: queue_instr(OP_HALT, pick_value(), AW'($urandom));
         1: queue_instr(OP_WIDTH'($urandom_range(OP_HALT + 1, (1 << OP_WIDTH) - 1)),
                        pick_value(), AW'($urandom));
         2: begin
            while (plan_ddepth > $urandom_range(0, 1)) queue_instr(OP_PRINT, '0, '0);
            if (plan_ddepth == 1) begin
               queue_instr(pick_arith(), '0, '0);
            end else if ($urandom_range(0, 1)) begin
               queue_instr(OP_DUP, '0, '0);
            end else begin
               queue_instr(OP_PRINT, '0, '0);
            end
         end
         3: begin
            while (plan_ddepth < DSTK_DEPTH) queue_instr(OP_PUSH, pick_value(), '0);
            queue_instr($urandom_range(0, 1) ? OP_PUSH : OP_DUP, pick_value(), '0);
         end
         4: begin
            while (plan_rdepth > 0) queue_instr(OP_RET, '0, '0);
            queue_instr(OP_RET, '0, '0);
         end
         default: begin
            while (plan_rdepth < RSTK_DEPTH) queue_instr(OP_CALL, '0, AW'($urandom));
            queue_instr(OP_CALL, '0, AW'($urandom));
         end
      endcase
      repeat (TAIL_ITEMS) begin
         queue_instr(OP_WIDTH'($urandom_range(0, (1 << OP_WIDTH) - 1)), $urandom,
                     AW'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver. It keeps push high until the request is taken and
   // then either offers the next pending instruction or idles for a burst.
   // Each edge assigns push at most once.
   // ------------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin : drive_requests
      instr_t nxt;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            nxt.opcode      = req_opcode;
            nxt.push_value  = req_push_value;
            nxt.call_target = req_call_target;
            expected_results.push_back(execute_instr(nxt));
         end
         if (!push || !full) begin
            if (req_gap > 0) begin
               req_gap--;
               push <= 1'b0;
            end else if (pending.size() != 0) begin
               nxt = pending.pop_front();
               push            <= 1'b1;
               req_opcode      <= nxt.opcode;
               req_push_value  <= nxt.push_value;
               req_call_target <= nxt.call_target;
               if (idle_on && $urandom_range(0, 9) == 0) begin
                  req_gap = $urandom_range(1, 13);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor. Every popped result is compared with the oldest
   // expectation. Once, after a few hundred results, it stops popping for
   // a long stretch so that both internal queues fill and full rises while
   // the driver keeps offering requests.
   // ------------------------------------------------------------------
   int rsp_gap = 0;
   int hold_left = 0;
   bit held_once = 1'b0;

   task automatic note_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("result %0d: %s differs, expected %0h, got %0h",
                  results_seen, what, want, got);
      end
   endtask

   // Counts down the one long hold-off of the receiver.
   always @(posedge clock) begin : hold_counter
      if (!held_once && results_seen >= HOLD_AFTER) begin
         held_once <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : check_results
      outcome_t want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               note_mismatch("result with no request outstanding, next_address",
                             '0, DW'(rsp_next_address));
            end else begin
               want = expected_results.pop_front();
               if (rsp_next_address !== want.next_address)
                  note_mismatch("next_address", DW'(want.next_address),
                                DW'(rsp_next_address));
               if (rsp_print_valid !== want.print_valid)
                  note_mismatch("print_valid", DW'(want.print_valid),
                                DW'(rsp_print_valid));
               if (rsp_print_value !== want.print_value)
                  note_mismatch("print_value", want.print_value, rsp_print_value);
               if (rsp_halted !== want.halted)
                  note_mismatch("halted", DW'(want.halted), DW'(rsp_halted));
               if (rsp_status !== want.status)
                  note_mismatch("status", DW'(want.status), DW'(rsp_status));
            end
            results_seen++;
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(0, 12);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Hard stop in case the core stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("threaded_stack_machine_core_unit: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencing. The entry address is rewritten at the start of every
   // phase, while the core is idle; the stacks carry over from phase to
   // phase, only the instruction address restarts.
   // ------------------------------------------------------------------
   task automatic write_entry(logic [AW-1:0] addr);
      @(posedge clock);
      valid             <= 1'b1;
      csr_entry_address <= addr;
      do @(posedge clock); while (!ready);
      exec_addr  = addr;
      valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending.size() != 0 || push || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [AW-1:0] entries [NUM_PHASES];
      entries[0] = '1;
      entries[1] = '0;
      entries[2] = AW'($urandom_range(1, (1 << AW) - 2));
      entries[3] = AW'($urandom_range(1, (1 << AW) - 2));
      entries[4] = AW'((1 << AW) - 2);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_entry(entries[phase]);
         // The third phase runs with no idling at all, and so does the
         // last one, which carries the stopping instruction.
         idle_on = (phase != 2) && (phase != NUM_PHASES - 1);
         if (phase == 0) queue_directed();
         repeat (PHASE_ITEMS) queue_random_instr();
         if (phase == NUM_PHASES - 1) queue_stop_and_tail();
         wait_drained();
      end
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("threaded_stack_machine_core_unit: match");
      end else begin
         $display("threaded_stack_machine_core_unit: mismatch");
      end
      $finish;
   end

endmodule
